[rtl/core/ring_buffer_deque_defines.svh]
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define RBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rbd_pkg.sv]
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int COUNT_OUT_W = 11;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_FRONT = 3'd4,
    OP_READ_BACK  = 3'd5
  } op_t;

  typedef struct packed {
    logic load_req;
    logic execute;
    logic load_read;
  } rbd_cmd_t;

  typedef struct packed {
    logic store_read;
  } rbd_status_t;

endpackage

[rtl/core/rbd_ram.sv]
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/rbd_ctrl.sv]
`timescale 1ns / 1ps
`include "ring_buffer_deque_defines.svh"

module rbd_ctrl import rbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rbd_cmd_t    cmd,
  input  rbd_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EXEC    = 4'b0010,
    ST_CAPTURE = 4'b0100,
    ST_OUT     = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    rsp_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = status.store_read ? ST_CAPTURE : ST_OUT;
      end
      ST_CAPTURE: begin
        // The store's read data is registered, so it is taken in the cycle after the read.
        cmd.load_read = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `RBD_ASSERT_NEXT(a_exec_single, clk, rst, cmd.execute, !cmd.execute, "execute lasted two cycles")
  `RBD_ASSERT_NEXT(a_accept_exec, clk, rst, req_valid && !req_stall, cmd.execute, "request not executed")
  `RBD_ASSERT_NEXT(a_one_result, clk, rst, rsp_valid && !rsp_stall, !rsp_valid, "result repeated")

endmodule

[rtl/core/rbd_datapath.sv]
`timescale 1ns / 1ps
`include "ring_buffer_deque_defines.svh"

module rbd_datapath import rbd_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rbd_cmd_t                      cmd,
  output rbd_status_t                   status,
  input  logic [OP_W-1:0]               operation,
  input  logic signed [WORD_W-1:0]      push_value,
  output logic signed [WORD_W-1:0]      read_value,
  output logic                          failed,
  output logic [COUNT_OUT_W-1:0]        entry_count,
  output logic                          is_empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_INDEX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  op_t                      op_q;
  logic signed [WORD_W-1:0] value_q;
  logic [IW-1:0]            head;
  logic [IW-1:0]            tail;
  logic [CW-1:0]            count;
  logic [IW-1:0]            head_next;
  logic [IW-1:0]            tail_next;
  logic [CW-1:0]            count_next;
  logic                     fail_next;
  logic signed [WORD_W-1:0] value_next;
  logic [IW-1:0]            head_inc;
  logic [IW-1:0]            head_dec;
  logic [IW-1:0]            tail_inc;
  logic [IW-1:0]            tail_dec;
  logic                     empty;
  logic                     full;
  logic                     wr_need;
  logic                     rd_need;
  logic                     wr_en;
  logic                     rd_en;
  logic [IW-1:0]            wr_addr;
  logic [IW-1:0]            rd_addr;
  logic [WORD_W-1:0]        rd_data;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign empty    = (count == '0);
  assign full     = (count == FULL_COUNT);
  assign head_inc = (head == LAST_INDEX) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_INDEX : head - 1'b1;
  assign tail_inc = (tail == LAST_INDEX) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST_INDEX : tail - 1'b1;

  always_comb begin
    wr_need    = 1'b0;
    rd_need    = 1'b0;
    wr_addr    = tail;
    rd_addr    = head;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    fail_next  = 1'b0;
    value_next = '0;
    unique case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          fail_next = 1'b1;
        end else begin
          wr_need    = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          fail_next = 1'b1;
        end else begin
          wr_need    = 1'b1;
          wr_addr    = tail;
          tail_next  = tail_inc;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          fail_next  = 1'b1;
          value_next = EMPTY_WORD;
        end else begin
          rd_need    = 1'b1;
          rd_addr    = head;
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          fail_next  = 1'b1;
          value_next = EMPTY_WORD;
        end else begin
          rd_need    = 1'b1;
          rd_addr    = tail_dec;
          tail_next  = tail_dec;
          count_next = count - 1'b1;
        end
      end
      OP_READ_FRONT: begin
        if (empty) begin
          fail_next  = 1'b1;
          value_next = EMPTY_WORD;
        end else begin
          rd_need = 1'b1;
          rd_addr = head;
        end
      end
      OP_READ_BACK: begin
        if (empty) begin
          fail_next  = 1'b1;
          value_next = EMPTY_WORD;
        end else begin
          rd_need = 1'b1;
          rd_addr = tail_dec;
        end
      end
      default: begin
        // An unknown operation changes nothing and reports a failure.
        fail_next = 1'b1;
      end
    endcase
  end

  assign wr_en             = cmd.execute && wr_need;
  assign rd_en             = cmd.execute && rd_need;
  assign status.store_read = rd_need;

  rbd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(value_q),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.execute) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q    <= op_t'(operation);
      value_q <= push_value;
    end
    if (cmd.execute) begin
      failed     <= fail_next;
      read_value <= value_next;
    end
    if (cmd.load_read) begin
      read_value <= rd_data;
    end
  end

  // The count register only moves during execution, so it already holds the
  // count after the request while the result is offered.
  assign count_ext   = {{COUNT_OUT_W{1'b0}}, count};
  assign entry_count = count_ext[COUNT_OUT_W-1:0];
  assign is_empty    = empty;

  `RBD_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= FULL_COUNT, "count beyond capacity")
  `RBD_ASSERT_NEXT(a_push_count, clk, rst, wr_en, count == $past(count) + 1'b1, "push count wrong")
  `RBD_ASSERT_NEXT(a_hold_state, clk, rst, !cmd.execute, $stable(head) && $stable(tail) && $stable(count), "state moved outside execution")

endmodule

[rtl/core/ring_buffer_deque.sv]
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words in a ring store of DEPTH entries.
// Each request (operation, push_value) gives exactly one result carrying the
// word popped or read (-1 with failed set when the queue is empty, 0 for
// pushes), the live count after the request and an empty flag; a push into a
// full queue is dropped and flagged, as are the unused operation codes. One
// request is worked at a time: after it is accepted, a push or a failed
// request passes through the execute state to the result state, and a pop
// or read also passes through a capture state, the extra step being the
// registered read port of the store. After the result is taken the block is
// ready again in the next cycle. The store needs no clearing after reset;
// only written entries are read.
module ring_buffer_deque import rbd_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [OP_W-1:0]          operation,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [WORD_W-1:0] read_value,
  output logic                     failed,
  output logic [COUNT_OUT_W-1:0]   entry_count,
  output logic                     is_empty
);

  rbd_cmd_t    cmd;
  rbd_status_t status;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cmd      (cmd),
    .status   (status)
  );

  rbd_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .operation  (operation),
    .push_value (push_value),
    .read_value (read_value),
    .failed     (failed),
    .entry_count(entry_count),
    .is_empty   (is_empty)
  );

endmodule
